### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  typedef enum logic {
    ALU_GCD,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic [1:0]         status;
  } out_t;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DZ  = 2'd1;
  localparam logic [1:0] STAT_OVF = 2'd2;

endpackage

`default_nettype wire

### rtl/core/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Exact arithmetic and comparison on two fractions with reduced results.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation (mode, a, b). A transfer
//   happens when in_valid is high and in_stall low. in_stall stays high
//   while an operation is being worked on.
//   out_valid/out_stall/out_data return one result per operation.
//   An unused mode or a zero denominator goes straight from the load state
//   to the done state; the other paths depend on mode and operand values.
//   Nearly all of the work is done in the shared GCD/divide unit: each
//   reduction is a binary GCD (one step per cycle) followed by two divisions.
//   mul/div/add/sub/inc/dec end with a reduction of the double-width result;
//   add/sub/inc/dec also run one GCD and two divisions on the denominators.
//   A single 32x32 multiplier is reused for all products, one per cycle.
//   The block works on one operation at a time.
//   The finished result sits in an output register; the next operation is
//   taken while that result still waits for the receiver. If the receiver
//   stalls and a second result is ready, the sequencer holds it.
//   Reset (rst_n low, synchronous) empties the output register and returns
//   the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam logic [PW-1:0] MAXV = PW'((64'd1 << (W - 1)) - 64'd1);

  localparam logic [3:0] MODE_NORM = 4'd0;
  localparam logic [3:0] MODE_ADD  = 4'd1;
  localparam logic [3:0] MODE_SUB  = 4'd2;
  localparam logic [3:0] MODE_MUL  = 4'd3;
  localparam logic [3:0] MODE_DIV  = 4'd4;
  localparam logic [3:0] MODE_LT   = 4'd5;
  localparam logic [3:0] MODE_LE   = 4'd6;
  localparam logic [3:0] MODE_GT   = 4'd7;
  localparam logic [3:0] MODE_GE   = 4'd8;
  localparam logic [3:0] MODE_EQ   = 4'd9;
  localparam logic [3:0] MODE_NE   = 4'd10;
  localparam logic [3:0] MODE_INC  = 4'd11;
  localparam logic [3:0] MODE_DEC  = 4'd12;
  localparam logic [3:0] MODE_NEG  = 4'd13;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_RG, S_RGW, S_RQ1, S_RQ1W, S_RQ2, S_RQ2W, S_RFIX,
    S_OP,
    S_CMP1, S_CMP2, S_CMPF,
    S_MUL1, S_MUL2, S_DIV1, S_DIV2,
    S_ADDG, S_ADDGW, S_ADDQ1, S_ADDQ1W, S_ADDQ2, S_ADDQ2W,
    S_ADDM1, S_ADDM2, S_ADDM3, S_ADDC,
    S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RET_A,
    RET_B,
    RET_FIN
  } ret_t;

  state_t          state_r;
  ret_t            ret_r;
  logic [3:0]      mode_r;
  logic            an_r, bn_r, rn_r;
  logic [W-1:0]    am_r, ad_r, bm_r, bd_r;
  logic [PW-1:0]   rm_r, rd_r, g_r, t1_r, t2_r;
  logic [W-1:0]    q1_r, q2_r;
  out_t            rs_r;
  logic            out_valid_r;
  out_t            out_data_r;

  // split helper: sign and magnitude of the low W bits
  function automatic logic [W:0] split_word(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return {v[W-1], (v[W-1] ? (~v + 1'b1) : v)};
  endfunction

  logic [W:0] sa_n, sa_d, sb_n, sb_d;
  assign sa_n = split_word(in_data.a_num);
  assign sa_d = split_word(in_data.a_den);
  assign sb_n = split_word(in_data.b_num);
  assign sb_d = split_word(in_data.b_den);

  logic binary;
  assign binary = (mode_r >= MODE_ADD) && (mode_r <= MODE_NE);

  // shared multiplier
  logic [W-1:0]  mul_x, mul_y;
  logic [PW-1:0] prod;
  always_comb begin
    mul_x = am_r;
    mul_y = bd_r;
    unique case (state_r)
      S_CMP2:  begin mul_x = bm_r; mul_y = ad_r; end
      S_MUL1:  begin mul_x = am_r; mul_y = bm_r; end
      S_MUL2:  begin mul_x = ad_r; mul_y = bd_r; end
      S_DIV2:  begin mul_x = ad_r; mul_y = bm_r; end
      S_ADDM1: begin mul_x = am_r; mul_y = q1_r; end
      S_ADDM2: begin mul_x = bm_r; mul_y = q2_r; end
      S_ADDM3: begin mul_x = q2_r; mul_y = bd_r; end
      default: begin mul_x = am_r; mul_y = bd_r; end
    endcase
  end
  assign prod = PW'(mul_x) * PW'(mul_y);

  // shared GCD / divide unit
  alu_req_t      alu_req;
  logic [PW-1:0] alu_x, alu_y, alu_res;
  logic          alu_done;
  always_comb begin
    alu_req = '{start: 1'b0, op: ALU_GCD};
    alu_x   = rm_r;
    alu_y   = rd_r;
    unique case (state_r)
      S_RG:    begin alu_req = '{start: 1'b1, op: ALU_GCD}; end
      S_RQ1:   begin alu_req = '{start: 1'b1, op: ALU_DIV}; alu_y = g_r; end
      S_RQ2:   begin alu_req = '{start: 1'b1, op: ALU_DIV}; alu_x = rd_r;
                     alu_y = g_r; end
      S_ADDG:  begin alu_req = '{start: 1'b1, op: ALU_GCD}; alu_x = PW'(ad_r);
                     alu_y = PW'(bd_r); end
      S_ADDQ1: begin alu_req = '{start: 1'b1, op: ALU_DIV}; alu_x = PW'(bd_r);
                     alu_y = g_r; end
      S_ADDQ2: begin alu_req = '{start: 1'b1, op: ALU_DIV}; alu_x = PW'(ad_r);
                     alu_y = g_r; end
      default: ;
    endcase
  end

  rau_alu #(.PW(PW)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .x     (alu_x),
    .y     (alu_y),
    .done  (alu_done),
    .res   (alu_res)
  );

  // reduced value with the zero case folded in
  logic          fix_n;
  logic [PW-1:0] fix_d;
  assign fix_n = (rm_r == '0) ? 1'b0 : rn_r;
  assign fix_d = (rm_r == '0) ? PW'(1) : rd_r;

  // signed cross products for the compare modes
  logic signed [PW:0] lhs, rhs;
  logic               cmp;
  assign lhs = an_r ? -$signed({1'b0, t1_r}) : $signed({1'b0, t1_r});
  assign rhs = bn_r ? -$signed({1'b0, t2_r}) : $signed({1'b0, t2_r});
  always_comb begin
    case (mode_r)
      MODE_LT: cmp = (lhs <  rhs);
      MODE_LE: cmp = (lhs <= rhs);
      MODE_GT: cmp = (lhs >  rhs);
      MODE_GE: cmp = (lhs >= rhs);
      MODE_EQ: cmp = (lhs == rhs);
      default: cmp = (lhs != rhs);
    endcase
  end

  logic [63:0] rm64;
  logic [31:0] rnum;
  assign rm64 = 64'(rm_r);
  assign rnum = rn_r ? (32'd0 - rm64[31:0]) : rm64[31:0];

  // result moves into the output register when that register frees up
  logic out_load;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_data.mode;
            an_r    <= sa_n[W] ^ sa_d[W];
            am_r    <= sa_n[W-1:0];
            ad_r    <= sa_d[W-1:0];
            bn_r    <= sb_n[W] ^ sb_d[W];
            bm_r    <= sb_n[W-1:0];
            bd_r    <= sb_d[W-1:0];
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (mode_r > MODE_NEG) begin
            rs_r    <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: STAT_OK};
            state_r <= S_DONE;
          end else if (ad_r == '0 || (binary && bd_r == '0)) begin
            rs_r    <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: STAT_DZ};
            state_r <= S_DONE;
          end else begin
            rn_r    <= an_r;
            rm_r    <= PW'(am_r);
            rd_r    <= PW'(ad_r);
            ret_r   <= RET_A;
            state_r <= S_RG;
          end
        end
        // reduction of (rn, rm, rd) by its GCD
        S_RG:   state_r <= S_RGW;
        S_RGW: begin
          if (alu_done) begin
            g_r     <= alu_res;
            state_r <= S_RQ1;
          end
        end
        S_RQ1:  state_r <= S_RQ1W;
        S_RQ1W: begin
          if (alu_done) begin
            rm_r    <= alu_res;
            state_r <= S_RQ2;
          end
        end
        S_RQ2:  state_r <= S_RQ2W;
        S_RQ2W: begin
          if (alu_done) begin
            rd_r    <= alu_res;
            state_r <= S_RFIX;
          end
        end
        S_RFIX: begin
          unique case (ret_r)
            RET_A: begin
              an_r <= fix_n;
              am_r <= rm_r[W-1:0];
              ad_r <= fix_d[W-1:0];
              if (binary) begin
                rn_r    <= bn_r;
                rm_r    <= PW'(bm_r);
                rd_r    <= PW'(bd_r);
                ret_r   <= RET_B;
                state_r <= S_RG;
              end else begin
                rn_r    <= fix_n;
                rd_r    <= fix_d;
                state_r <= S_OP;
              end
            end
            RET_B: begin
              rn_r    <= fix_n;
              rd_r    <= fix_d;
              bn_r    <= fix_n;
              bm_r    <= rm_r[W-1:0];
              bd_r    <= fix_d[W-1:0];
              state_r <= S_OP;
            end
            default: begin
              rn_r    <= fix_n;
              rd_r    <= fix_d;
              state_r <= S_FIN;
            end
          endcase
        end
        S_OP: begin
          rn_r  <= (mode_r == MODE_NEG && am_r != '0) ? ~an_r : an_r;
          rm_r  <= PW'(am_r);
          rd_r  <= PW'(ad_r);
          ret_r <= RET_FIN;
          case (mode_r)
            MODE_NORM: state_r <= S_FIN;
            MODE_NEG:  state_r <= S_FIN;
            MODE_MUL:  state_r <= S_MUL1;
            MODE_DIV: begin
              if (bm_r == '0) begin
                rs_r    <= '{res_num: '0, res_den: '0, cmp_true: 1'b0,
                             status: STAT_DZ};
                state_r <= S_DONE;
              end else begin
                state_r <= S_DIV1;
              end
            end
            MODE_ADD: state_r <= S_ADDG;
            MODE_SUB: begin
              bn_r    <= (bm_r != '0) ? ~bn_r : bn_r;
              state_r <= S_ADDG;
            end
            MODE_INC, MODE_DEC: begin
              bn_r    <= (mode_r == MODE_DEC);
              bm_r    <= W'(1);
              bd_r    <= W'(1);
              state_r <= S_ADDG;
            end
            default: state_r <= S_CMP1;
          endcase
        end
        S_CMP1: begin
          t1_r    <= prod;
          state_r <= S_CMP2;
        end
        S_CMP2: begin
          t2_r    <= prod;
          state_r <= S_CMPF;
        end
        S_CMPF: begin
          rs_r    <= '{res_num: '0, res_den: '0, cmp_true: cmp, status: STAT_OK};
          state_r <= S_DONE;
        end
        S_MUL1: begin
          rm_r    <= prod;
          rn_r    <= an_r ^ bn_r;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          rd_r    <= prod;
          state_r <= S_RG;
        end
        S_DIV1: begin
          rm_r    <= prod;
          rn_r    <= an_r ^ bn_r;
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          rd_r    <= prod;
          state_r <= S_RG;
        end
        // a + b over the common denominator lcm(ad, bd)
        S_ADDG:  state_r <= S_ADDGW;
        S_ADDGW: begin
          if (alu_done) begin
            g_r     <= alu_res;
            state_r <= S_ADDQ1;
          end
        end
        S_ADDQ1:  state_r <= S_ADDQ1W;
        S_ADDQ1W: begin
          if (alu_done) begin
            q1_r    <= alu_res[W-1:0];
            state_r <= S_ADDQ2;
          end
        end
        S_ADDQ2:  state_r <= S_ADDQ2W;
        S_ADDQ2W: begin
          if (alu_done) begin
            q2_r    <= alu_res[W-1:0];
            state_r <= S_ADDM1;
          end
        end
        S_ADDM1: begin
          t1_r    <= prod;
          state_r <= S_ADDM2;
        end
        S_ADDM2: begin
          t2_r    <= prod;
          state_r <= S_ADDM3;
        end
        S_ADDM3: begin
          rd_r    <= prod;
          state_r <= S_ADDC;
        end
        S_ADDC: begin
          if (an_r == bn_r) begin
            rn_r <= an_r;
            rm_r <= t1_r + t2_r;
          end else if (t1_r >= t2_r) begin
            rn_r <= an_r;
            rm_r <= t1_r - t2_r;
          end else begin
            rn_r <= bn_r;
            rm_r <= t2_r - t1_r;
          end
          state_r <= S_RG;
        end
        S_FIN: begin
          if (rm_r > MAXV || rd_r > MAXV) begin
            rs_r <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: STAT_OVF};
          end else begin
            rs_r <= '{res_num: rnum, res_den: 31'(rd_r), cmp_true: 1'b0,
                      status: STAT_OK};
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r <= rs_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/rau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_alu
// Shared multi-cycle unit: binary GCD (one step per cycle) and restoring
// unsigned division (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module rau_alu
  import rau_pkg::*;
#(
  parameter int PW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire alu_req_t      req,
  input  wire logic [PW-1:0] x,
  input  wire logic [PW-1:0] y,
  output logic               done,
  output logic [PW-1:0]      res
);

  localparam int KW = $clog2(PW);

  typedef enum logic [1:0] {
    A_IDLE,
    A_GCD,
    A_DIV
  } alu_state_t;

  alu_state_t      state_r;
  logic [PW-1:0]   gx_r, gy_r;
  logic [KW-1:0]   k_r;
  logic [PW:0]     rem_r;
  logic [PW-1:0]   q_r;
  logic [PW-1:0]   d_r;
  logic [KW-1:0]   cnt_r;
  logic            done_r;
  logic [PW-1:0]   res_r;

  logic [PW:0]     rem_sh;
  logic            qbit;
  logic            fin;

  assign rem_sh = {rem_r[PW-1:0], q_r[PW-1]};
  assign qbit   = (rem_sh >= {1'b0, d_r});
  assign done   = done_r;
  assign res    = res_r;

  // last cycle of a GCD or a division
  assign fin = ((state_r == A_GCD) && ((gx_r == '0) || (gy_r == '0))) ||
               ((state_r == A_DIV) && (cnt_r == KW'(PW - 1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= fin;
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            if (req.op == ALU_GCD) begin
              gx_r    <= x;
              gy_r    <= y;
              k_r     <= '0;
              state_r <= A_GCD;
            end else begin
              q_r     <= x;
              d_r     <= y;
              rem_r   <= '0;
              cnt_r   <= '0;
              state_r <= A_DIV;
            end
          end
        end
        A_GCD: begin
          if (gx_r == '0) begin
            res_r   <= gy_r << k_r;
            state_r <= A_IDLE;
          end else if (gy_r == '0) begin
            res_r   <= gx_r << k_r;
            state_r <= A_IDLE;
          end else if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1;
            gy_r <= gy_r >> 1;
            k_r  <= k_r + 1'b1;
          end else if (!gx_r[0]) begin
            gx_r <= gx_r >> 1;
          end else if (!gy_r[0]) begin
            gy_r <= gy_r >> 1;
          end else if (gx_r >= gy_r) begin
            gx_r <= gx_r - gy_r;
          end else begin
            gy_r <= gy_r - gx_r;
          end
        end
        A_DIV: begin
          rem_r <= qbit ? (rem_sh - {1'b0, d_r}) : rem_sh;
          q_r   <= {q_r[PW-2:0], qbit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == KW'(PW - 1)) begin
            res_r   <= {q_r[PW-2:0], qbit};
            state_r <= A_IDLE;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/rational_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb
// Self-checking bench for the rational arithmetic unit. Operations go in
// through the valid/stall input channel. A behavioral model of fraction
// reduction, add/sub/mul/div, compare and the unary modes predicts each
// result, and the result is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------

module rational_arithmetic_unit_core_tb;
  import rau_pkg::*;

  localparam int          WORD_BITS = 32;
  localparam int          SETTLE    = 1500;   // idle wait after the final drain
  localparam bit [63:0]   MAX_MAG   = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  // Mode codes
  localparam logic [3:0] M_NORM = 4'd0,  M_ADD = 4'd1,  M_SUB = 4'd2;
  localparam logic [3:0] M_MUL  = 4'd3,  M_DIV = 4'd4,  M_LT  = 4'd5;
  localparam logic [3:0] M_LE   = 4'd6,  M_GT  = 4'd7,  M_GE  = 4'd8;
  localparam logic [3:0] M_EQ   = 4'd9,  M_NE  = 4'd10, M_INC = 4'd11;
  localparam logic [3:0] M_DEC  = 4'd12, M_NEG = 4'd13, M_UNUSED = 4'd14;
  localparam logic [3:0] M_SPARE = 4'd15;

  typedef struct {
    bit        neg;
    bit [63:0] mag;
    bit [63:0] den;
  } frac_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  out_t pending_results[$];
  int   mismatch_count;
  bit   idle_en;
  bit   long_hold_req;

  rational_arithmetic_unit_core #(.WORD_BITS(WORD_BITS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Fraction model
  // --------------------------------------------------------------------------
  function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
    bit [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void reduce_frac(inout frac_t f);
    bit [63:0] g;
    g = gcd64(f.mag, f.den);
    if (g != 0) begin
      f.mag = f.mag / g;
      f.den = f.den / g;
    end
    // zero is always +0/1
    if (f.mag == 0) begin
      f.neg = 1'b0;
      f.den = 64'd1;
    end
  endfunction

  // Sign to numerator, then reduce. Returns 0 on a zero denominator.
  function automatic bit load_frac(logic [31:0] num, logic [31:0] den, output frac_t f);
    bit nn, dn;
    bit [63:0] nm, dm;
    nn = num[31];
    dn = den[31];
    nm = nn ? (64'h1_0000_0000 - {32'h0, num}) : {32'h0, num};
    dm = dn ? (64'h1_0000_0000 - {32'h0, den}) : {32'h0, den};
    f.neg = (nn != dn);
    f.mag = nm;
    f.den = dm;
    if (dm == 0) return 1'b0;
    reduce_frac(f);
    return 1'b1;
  endfunction

  function automatic frac_t sum_frac(frac_t a, frac_t b);
    frac_t r;
    bit [63:0] g, x, y;
    g = gcd64(a.den, b.den);
    x = a.mag * (b.den / g);
    y = b.mag * (a.den / g);
    r.den = (a.den / g) * b.den;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = x + y;
    end else if (x >= y) begin
      r.neg = a.neg;
      r.mag = x - y;
    end else begin
      r.neg = b.neg;
      r.mag = y - x;
    end
    reduce_frac(r);
    return r;
  endfunction

  function automatic out_t predict_result(in_t op);
    out_t  res;
    frac_t a, b, r;
    longint lhs, rhs;
    res = '0;
    if (op.mode > M_NEG) return res;
    if (!load_frac(op.a_num, op.a_den, a)) begin
      res.status = STAT_DZ;
      return res;
    end
    b = '{neg: 1'b0, mag: 64'd0, den: 64'd1};
    if (op.mode >= M_ADD && op.mode <= M_NE) begin
      if (!load_frac(op.b_num, op.b_den, b)) begin
        res.status = STAT_DZ;
        return res;
      end
    end
    if (op.mode >= M_LT && op.mode <= M_NE) begin
      lhs = longint'(a.mag * b.den);
      rhs = longint'(b.mag * a.den);
      if (a.neg) lhs = -lhs;
      if (b.neg) rhs = -rhs;
      case (op.mode)
        M_LT: res.cmp_true = (lhs < rhs);
        M_LE: res.cmp_true = (lhs <= rhs);
        M_GT: res.cmp_true = (lhs > rhs);
        M_GE: res.cmp_true = (lhs >= rhs);
        M_EQ: res.cmp_true = (lhs == rhs);
        default: res.cmp_true = (lhs != rhs);
      endcase
      return res;
    end
    r = a;
    case (op.mode)
      M_ADD: r = sum_frac(a, b);
      M_SUB: begin
        if (b.mag != 0) b.neg = !b.neg;
        r = sum_frac(a, b);
      end
      M_MUL: begin
        r.neg = (a.neg != b.neg);
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
        reduce_frac(r);
      end
      M_DIV: begin
        if (b.mag == 0) begin
          res.status = STAT_DZ;
          return res;
        end
        r.neg = (a.neg != b.neg);
        r.mag = a.mag * b.den;
        r.den = a.den * b.mag;
        reduce_frac(r);
      end
      M_INC, M_DEC: begin
        b = '{neg: (op.mode == M_DEC), mag: 64'd1, den: 64'd1};
        r = sum_frac(a, b);
      end
      M_NEG: if (r.mag != 0) r.neg = !r.neg;
      default: ;
    endcase
    if (r.mag > MAX_MAG || r.den > MAX_MAG) begin
      res.status = STAT_OVF;
      return res;
    end
    res.res_num = r.neg ? -r.mag[31:0] : r.mag[31:0];
    res.res_den = r.den[30:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one transfer per call, optional idle burst first
  // --------------------------------------------------------------------------
  task automatic send_op(in_t op);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(op));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_t make_op(logic [3:0] mode, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    in_t op;
    op.mode  = mode;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    return op;
  endfunction

  // Mostly small values so results fit; some full-width and corner words.
  function automatic logic [31:0] rand_word(bit is_den);
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: w = $urandom_range(0, 60);
      5, 6:          w = $urandom_range(0, 100000);
      7:             w = $urandom;
      8: case ($urandom_range(0, 3))
           0: w = 32'h8000_0000;
           1: w = 32'h7fff_ffff;
           2: w = 32'h0001_0000;
           default: w = 32'd1;
         endcase
      default:       w = $urandom_range(1, 65535) * $urandom_range(1, 32);
    endcase
    if ($urandom_range(0, 1)) w = -w;
    // keep zero denominators occasional
    if (is_den && w == 0 && $urandom_range(0, 3) != 0) w = 32'd1 + $urandom_range(0, 9);
    return w;
  endfunction

  function automatic in_t rand_op();
    logic [3:0] mode;
    mode = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(14, 15))
                                        : 4'($urandom_range(0, 13));
    return make_op(mode, rand_word(0), rand_word(1), rand_word(0), rand_word(1));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_op(make_op(M_NORM, 32'd6, -32'd4, 32'd0, 32'd0));          // sign moves up
    send_op(make_op(M_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0));   // most neg: ovf
    send_op(make_op(M_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0));   // -2^31/-2^31 = 1
    send_op(make_op(M_NORM, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
    send_op(make_op(M_NORM, 32'd0, -32'd7, 0, 0));                  // zero result
    send_op(make_op(M_NORM, 32'd5, 32'd0, 0, 0));                   // zero den
    send_op(make_op(M_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    send_op(make_op(M_ADD, 32'd1, 32'd2, 32'd0, 32'd0));            // b zero den
    send_op(make_op(M_SUB, 32'd1, 32'd3, 32'd1, 32'd3));            // zero result
    send_op(make_op(M_SUB, 32'h7fff_ffff, 32'd1, -32'd1, 32'd1));   // overflow
    send_op(make_op(M_MUL, -32'd4, 32'd9, 32'd3, -32'd8));
    send_op(make_op(M_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 1)); // overflow
    send_op(make_op(M_DIV, 32'd2, 32'd3, 32'd4, 32'd5));
    send_op(make_op(M_DIV, 32'd2, 32'd3, 32'd0, 32'd5));            // div by zero
    send_op(make_op(M_LT, -32'd1, 32'd2, 32'd1, 32'd3));
    send_op(make_op(M_LE, 32'd2, 32'd4, 32'd1, 32'd2));
    send_op(make_op(M_GT, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1));
    send_op(make_op(M_GE, 32'd1, 32'd3, 32'd1, 32'd2));
    send_op(make_op(M_EQ, 32'd3, -32'd6, -32'd1, 32'd2));
    send_op(make_op(M_NE, 32'd3, 32'd6, 32'd1, 32'd2));
    send_op(make_op(M_INC, 32'h7fff_fffe, 32'd1, 32'hffff_ffff, 32'hffff_ffff));
    send_op(make_op(M_DEC, 32'h8000_0001, 32'd1, 32'd0, 32'd0));    // hits -2^31: ovf
    send_op(make_op(M_NEG, 32'd0, 32'd5, 32'd0, 32'd0));            // -0 stays +0
    send_op(make_op(M_UNUSED, 32'd1, 32'd0, 32'd1, 32'd0));
    send_op(make_op(M_SPARE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
  endtask

  task automatic test_random(int count);
    repeat (count) send_op(rand_op());
  endtask

  // Receiver holds off while the sender keeps offering; the block backs up.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (6) send_op(rand_op());
  endtask

  // Sender goes quiet until every outstanding result is back, then sends more.
  task automatic test_drain_pause();
    wait_drained();
    test_random(20);
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall driver
  // --------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (5000) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.res_num !== want.res_num || out_data.res_den !== want.res_den ||
            out_data.cmp_true !== want.cmp_true || out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected num=%0d den=%0d cmp=%0b st=%0d, ",
                      "got num=%0d den=%0d cmp=%0b st=%0d"},
                     want.res_num, want.res_den, want.cmp_true, want.status,
                     out_data.res_num, out_data.res_den, out_data.cmp_true,
                     out_data.status);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    idle_en        = 1'b1;
    long_hold_req  = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(150);
    test_backpressure();
    test_drain_pause();
    test_random(150);
    idle_en = 1'b0;   // closing stretch runs back to back
    test_random(100);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
